// ----- design/iamd_pkg.sv -----
// Package for the integer ALU with multiply and divide.
// Holds the operation codes, word structs and the queue entry type; no dependencies.
package iamd_pkg;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MULL  = 4'd2,
        OP_MULLU = 4'd3,
        OP_MULH  = 4'd4,
        OP_MULHU = 4'd5,
        OP_DIV   = 4'd6,
        OP_DIVU  = 4'd7,
        OP_MOD   = 4'd8,
        OP_MODU  = 4'd9
    } op_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [15:0] immediate;
        logic        use_immediate;
        logic [31:0] current_pc;
    } in_word_t;

    typedef struct packed {
        logic [31:0] value;
        logic        divide_fault;
        logic [31:0] fault_pc;
        logic [31:0] fault_dividend;
    } out_word_t;

    // Unit class chosen in the front end.
    typedef enum logic [1:0] {
        CLS_ALU  = 2'd0,
        CLS_MUL  = 2'd1,
        CLS_DIV  = 2'd2,
        CLS_NONE = 2'd3
    } cls_t;

    // Classified operation handed from front to back.
    typedef struct packed {
        cls_t        cls;
        logic        sgn;      // signed multiply / divide
        logic        hi_rem;   // high word of product, or remainder
        logic        is_sub;
        logic        fault;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] pc;
    } op_word_t;

endpackage

// ----- design/integer_alu_mul_div_top.sv -----
// Integer ALU with multiply and divide: usage notes and structure.
// The in channel takes one word per cycle while in_ready is high: kind,
// operand_a, operand_b, immediate, use_immediate and current_pc. The out
// channel returns one word per input word, in order: value, divide_fault,
// fault_pc, fault_dividend. Structure: front end register, two-entry
// queue, then a back-end pipeline of WORD_BITS+3 stages (operand setup,
// one restoring divide bit per stage, one multiply stage, signed fix-up
// and result stage). Every operation takes the full pipe.
// Throughput: one word per cycle while out_ready stays high, set by the
// fully pipelined divider.
// A zero divisor for div/mod gives divide_fault with pc and dividend.
// Reset (rst_n low, asynchronous) empties the front register, the queue
// and the pipeline; no word is in flight afterwards.
// When the receiver holds out_ready low the back pipeline freezes, the
// queue fills, and in_ready falls only once the front register is stuck.
module integer_alu_mul_div_top #(
    parameter int WORD_BITS = 32,
    parameter int IMM_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  iamd_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output iamd_pkg::out_word_t out_data
);

    logic               f_valid;
    logic               f_ready;
    iamd_pkg::op_word_t f_data;
    logic               q_valid;
    logic               q_ready;
    iamd_pkg::op_word_t q_data;

    iamd_front #(.WORD_BITS(WORD_BITS), .IMM_BITS(IMM_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .op_valid(f_valid), .op_ready(f_ready), .op_data(f_data)
    );

    iamd_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
    );

    iamd_back #(.WORD_BITS(WORD_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .op_valid(q_valid), .op_ready(q_ready), .op_data(q_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

endmodule

// ----- design/iamd_front.sv -----
// Front end: takes input words, selects the second operand and classifies the operation.
// Depends on iamd_pkg.
module iamd_front #(
    parameter int WORD_BITS = 32,
    parameter int IMM_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  iamd_pkg::in_word_t in_data,
    output logic               op_valid,
    input  logic               op_ready,
    output iamd_pkg::op_word_t op_data
);

    // immediate bits kept: no more than the field, the parameter or the word
    localparam int IB0 = (IMM_BITS < WORD_BITS) ? IMM_BITS : WORD_BITS;
    localparam int IB  = (IB0 < 16) ? IB0 : 16;

    logic               valid_reg;
    iamd_pkg::op_word_t data_reg;
    iamd_pkg::op_word_t data_next;
    logic [WORD_BITS-1:0] a_w;
    logic [WORD_BITS-1:0] b_w;
    logic [WORD_BITS-1:0] imm_w;

    assign in_ready = !valid_reg || op_ready;
    assign op_valid = valid_reg;
    assign op_data  = data_reg;

    always_comb
    begin
        imm_w = '0;
        imm_w[IB-1:0] = in_data.immediate[IB-1:0];
        a_w = in_data.operand_a[WORD_BITS-1:0];
        b_w = in_data.use_immediate ? imm_w : in_data.operand_b[WORD_BITS-1:0];
        data_next        = '0;
        data_next.a      = 32'(a_w);
        data_next.b      = 32'(b_w);
        data_next.pc     = in_data.current_pc;
        data_next.cls    = iamd_pkg::CLS_NONE;
        case (in_data.kind)
            iamd_pkg::OP_ADD:   data_next.cls = iamd_pkg::CLS_ALU;
            iamd_pkg::OP_SUB:
            begin
                data_next.cls    = iamd_pkg::CLS_ALU;
                data_next.is_sub = 1'b1;
            end
            iamd_pkg::OP_MULL:
            begin
                data_next.cls = iamd_pkg::CLS_MUL;
                data_next.sgn = 1'b1;
            end
            iamd_pkg::OP_MULLU: data_next.cls = iamd_pkg::CLS_MUL;
            iamd_pkg::OP_MULH:
            begin
                data_next.cls    = iamd_pkg::CLS_MUL;
                data_next.sgn    = 1'b1;
                data_next.hi_rem = 1'b1;
            end
            iamd_pkg::OP_MULHU:
            begin
                data_next.cls    = iamd_pkg::CLS_MUL;
                data_next.hi_rem = 1'b1;
            end
            iamd_pkg::OP_DIV:
            begin
                data_next.cls = iamd_pkg::CLS_DIV;
                data_next.sgn = 1'b1;
            end
            iamd_pkg::OP_DIVU:  data_next.cls = iamd_pkg::CLS_DIV;
            iamd_pkg::OP_MOD:
            begin
                data_next.cls    = iamd_pkg::CLS_DIV;
                data_next.sgn    = 1'b1;
                data_next.hi_rem = 1'b1;
            end
            iamd_pkg::OP_MODU:
            begin
                data_next.cls    = iamd_pkg::CLS_DIV;
                data_next.hi_rem = 1'b1;
            end
            default:            data_next.cls = iamd_pkg::CLS_NONE;
        endcase
        if (data_next.cls == iamd_pkg::CLS_DIV && b_w == '0)
        begin
            data_next.fault = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- design/iamd_queue.sv -----
// Two-entry FIFO between front and back ends.
// Depends on iamd_pkg.
module iamd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  iamd_pkg::op_word_t wr_data,
    output logic               rd_valid,
    input  logic               rd_ready,
    output iamd_pkg::op_word_t rd_data
);

    iamd_pkg::op_word_t mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       wr_en;
    logic       rd_en;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= !wp_reg;
            end
            if (rd_en)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule

// ----- design/iamd_back.sv -----
// Back end: pipelined add, multiply, radix-2 divide; one word per cycle unless stalled.
// Depends on iamd_pkg.
module iamd_back #(
    parameter int WORD_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_ready,
    input  iamd_pkg::op_word_t  op_data,
    output logic                out_valid,
    input  logic                out_ready,
    output iamd_pkg::out_word_t out_data
);

    localparam int W  = WORD_BITS;
    localparam int NS = W + 3; // setup, W divide steps, multiply stage, finish

    typedef struct packed {
        iamd_pkg::cls_t cls;
        logic           sgn;
        logic           hi_rem;
        logic           fault;
        logic           neg_q;
        logic           neg_r;
        logic [W-1:0]   a;
        logic [31:0]    pc;
        logic [W-1:0]   q;     // quotient bits shift in; dividend bits shift out
        logic [W:0]     r;     // partial remainder
        logic [W-1:0]   d;     // divisor magnitude, multiplier b, or ALU result
        logic [2*W-1:0] p;     // product
    } st_t;

    st_t  st_reg [NS];
    logic vl_reg [NS];
    logic adv;
    st_t  s0;
    logic [W-1:0] bw;

    function automatic st_t div_step(st_t s);
        st_t          t;
        logic [W:0]   sh;
        logic [W:0]   df;
        t  = s;
        if (s.cls == iamd_pkg::CLS_DIV)
        begin
            sh = {s.r[W-1:0], s.q[W-1]};
            df = sh - {1'b0, s.d};
            if (!df[W])
            begin
                t.r = df;
                t.q = {s.q[W-2:0], 1'b1};
            end
            else
            begin
                t.r = sh;
                t.q = {s.q[W-2:0], 1'b0};
            end
        end
        return t;
    endfunction

    // W x W unsigned product; the signed high word is fixed up a stage later
    function automatic st_t mul_stage(st_t s);
        st_t            t;
        logic [2*W-1:0] prod;
        t    = s;
        prod = s.q * s.d;
        if (s.cls == iamd_pkg::CLS_MUL)
        begin
            t.p = prod;
        end
        return t;
    endfunction

    // signed high word = unsigned high word - (a<0 ? b : 0) - (b<0 ? a : 0)
    function automatic st_t mul_fix(st_t s);
        st_t          t;
        logic [W-1:0] hi;
        t  = s;
        hi = s.p[2*W-1:W] - (s.q[W-1] ? s.d : '0) - (s.d[W-1] ? s.q : '0);
        if (s.cls == iamd_pkg::CLS_MUL && s.sgn)
        begin
            t.p[2*W-1:W] = hi;
        end
        return t;
    endfunction

    assign adv      = !vl_reg[NS-1] || out_ready;
    assign op_ready = adv;

    always_comb
    begin
        s0        = '0;
        bw        = op_data.b[W-1:0];
        s0.cls    = op_data.cls;
        s0.sgn    = op_data.sgn;
        s0.hi_rem = op_data.hi_rem;
        s0.fault  = op_data.fault;
        s0.a      = op_data.a[W-1:0];
        s0.pc     = op_data.pc;
        s0.neg_q  = op_data.sgn && (s0.a[W-1] != bw[W-1]);
        s0.neg_r  = op_data.sgn && s0.a[W-1];
        s0.q      = (op_data.sgn && s0.a[W-1]) ? (W'(0) - s0.a) : s0.a;
        s0.d      = (op_data.sgn && bw[W-1]) ? (W'(0) - bw) : bw;
        if (op_data.cls == iamd_pkg::CLS_ALU)
        begin
            s0.d = op_data.is_sub ? (s0.a - bw) : (s0.a + bw);
        end
        if (op_data.cls == iamd_pkg::CLS_MUL)
        begin
            s0.q = s0.a;
            s0.d = bw;
        end
    end

    // stage 0 latches; stages 1..W divide steps; stage W+1 multiply; last fixes sign
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                vl_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vl_reg[0] <= op_valid;
            for (int i = 1; i < NS; i++)
            begin
                vl_reg[i] <= vl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= s0;
            for (int i = 1; i <= W; i++)
            begin
                st_reg[i] <= div_step(st_reg[i-1]);
            end
            st_reg[W+1] <= mul_stage(st_reg[W]);
            st_reg[W+2] <= mul_fix(st_reg[W+1]);
        end
    end

    st_t          f;
    logic [W-1:0] res;
    logic [W-1:0] rr;

    always_comb
    begin
        f  = st_reg[NS-1];
        rr = f.r[W-1:0];
        case (f.cls)
            iamd_pkg::CLS_ALU: res = f.d;
            iamd_pkg::CLS_MUL: res = f.hi_rem ? f.p[2*W-1:W] : f.p[W-1:0];
            iamd_pkg::CLS_DIV:
            begin
                if (f.hi_rem)
                begin
                    res = f.neg_r ? (W'(0) - rr) : rr;
                end
                else
                begin
                    res = f.neg_q ? (W'(0) - f.q) : f.q;
                end
            end
            default: res = '0;
        endcase
        out_data = '0;
        if (f.fault)
        begin
            out_data.divide_fault   = 1'b1;
            out_data.fault_pc       = f.pc;
            out_data.fault_dividend = 32'(f.a);
        end
        else
        begin
            out_data.value = 32'(res);
        end
    end

    assign out_valid = vl_reg[NS-1];

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Testbench for integer_alu_mul_div_top: directed and random operations,
// predicted results checked in order. Depends on iamd_pkg and the top level.
module tb;

    localparam int LATENCY   = 36;
    localparam int MAX_CYCLE = 400000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    iamd_pkg::in_word_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    iamd_pkg::out_word_t out_data;

    iamd_pkg::out_word_t expected_words[$];
    int        error_count = 0;
    int        cycle_count = 0;
    bit        quiet = 1'b0;        // no idling on either side
    int        hold_off = 0;        // receiver hold-off, in cycles

    integer_alu_mul_div_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #5 clk = ~clk;

    function automatic iamd_pkg::out_word_t alu_result(iamd_pkg::in_word_t w);
        iamd_pkg::out_word_t r;
        logic [31:0] a, b, q, m;
        logic [63:0] p;
        logic        na, nb;
        r = '0;
        a = w.operand_a;
        b = w.use_immediate ? {16'd0, w.immediate} : w.operand_b;
        na = a[31];
        nb = b[31];
        case (w.kind)
            iamd_pkg::OP_ADD:   r.value = a + b;
            iamd_pkg::OP_SUB:   r.value = a - b;
            iamd_pkg::OP_MULL, iamd_pkg::OP_MULLU: r.value = a * b;
            iamd_pkg::OP_MULH:
            begin
                p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                r.value = p[63:32];
            end
            iamd_pkg::OP_MULHU:
            begin
                p = {32'd0, a} * {32'd0, b};
                r.value = p[63:32];
            end
            iamd_pkg::OP_DIV, iamd_pkg::OP_MOD, iamd_pkg::OP_DIVU, iamd_pkg::OP_MODU:
            begin
                if (b == 32'd0)
                begin
                    r.divide_fault = 1'b1;
                    r.fault_pc = w.current_pc;
                    r.fault_dividend = a;
                end
                else if (w.kind == iamd_pkg::OP_DIVU)
                    r.value = a / b;
                else if (w.kind == iamd_pkg::OP_MODU)
                    r.value = a % b;
                else
                begin
                    q = (na ? -a : a) / (nb ? -b : b);
                    m = (na ? -a : a) % (nb ? -b : b);
                    if (w.kind == iamd_pkg::OP_DIV)
                        r.value = (na != nb) ? -q : q;
                    else
                        r.value = na ? -m : m;
                end
            end
            default: r.value = '0;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        iamd_pkg::out_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word %h", out_data);
                error_count++;
            end
            else
            begin
                e = expected_words.pop_front();
                if (out_data.value !== e.value)
                begin
                    $error("value exp %h got %h", e.value, out_data.value);
                    error_count++;
                end
                if (out_data.divide_fault !== e.divide_fault)
                begin
                    $error("divide_fault exp %b got %b", e.divide_fault,
                           out_data.divide_fault);
                    error_count++;
                end
                if (out_data.fault_pc !== e.fault_pc)
                begin
                    $error("fault_pc exp %h got %h", e.fault_pc, out_data.fault_pc);
                    error_count++;
                end
                if (out_data.fault_dividend !== e.fault_dividend)
                begin
                    $error("fault_dividend exp %h got %h", e.fault_dividend,
                           out_data.fault_dividend);
                    error_count++;
                end
            end
        end
    end

    // receiver: random stall bursts, or a long hold-off when requested
    initial
    begin
        int gap;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off) @(negedge clk);
                hold_off = 0;
            end
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 13);
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // in_valid stays high after accept; a next-call gap or the end lowers it
    task automatic send_word(iamd_pkg::in_word_t w);
        int gap;
        if (!quiet && $urandom_range(0, 6) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        expected_words.push_back(alu_result(w));
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic iamd_pkg::in_word_t make_word(logic [3:0] k, logic [31:0] a,
                                                     logic [31:0] b, bit imm);
        iamd_pkg::in_word_t w;
        w.kind = k;
        w.operand_a = a;
        w.operand_b = b;
        w.immediate = 16'($urandom);
        w.use_immediate = imm;
        w.current_pc = $urandom;
        if (imm)
            w.immediate = b[15:0];
        return w;
    endfunction

    task automatic test_directed();
        send_word(make_word(iamd_pkg::OP_ADD, 32'hFFFF_FFFF, 32'd1, 1'b0));
        send_word(make_word(iamd_pkg::OP_SUB, 32'd0, 32'd1, 1'b0));
        send_word(make_word(iamd_pkg::OP_ADD, 32'h1234_5678, 32'h0000_FFFF, 1'b1));
        send_word(make_word(iamd_pkg::OP_MULL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        send_word(make_word(iamd_pkg::OP_MULLU, 32'h8000_0000, 32'd3, 1'b0));
        send_word(make_word(iamd_pkg::OP_MULH, 32'h8000_0000, 32'h8000_0000, 1'b0));
        send_word(make_word(iamd_pkg::OP_MULH, 32'hFFFF_FFFF, 32'd7, 1'b0));
        send_word(make_word(iamd_pkg::OP_MULHU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        send_word(make_word(iamd_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0));
        send_word(make_word(iamd_pkg::OP_MOD, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0));
        send_word(make_word(iamd_pkg::OP_DIV, 32'hFFFF_FFF9, 32'd2, 1'b0));
        send_word(make_word(iamd_pkg::OP_MOD, 32'hFFFF_FFF9, 32'd2, 1'b0));
        send_word(make_word(iamd_pkg::OP_MOD, 32'd7, 32'hFFFF_FFFE, 1'b0));
        send_word(make_word(iamd_pkg::OP_DIVU, 32'hFFFF_FFFF, 32'd2, 1'b0));
        send_word(make_word(iamd_pkg::OP_MODU, 32'hFFFF_FFFF, 32'd10, 1'b0));
        send_word(make_word(iamd_pkg::OP_DIV, 32'd5, 32'd0, 1'b0));
        send_word(make_word(iamd_pkg::OP_MOD, 32'hDEAD_BEEF, 32'd0, 1'b1));
        send_word(make_word(iamd_pkg::OP_DIVU, 32'd9, 32'd0, 1'b0));
        send_word(make_word(iamd_pkg::OP_MODU, 32'd9, 32'd0, 1'b1));
        send_word(make_word(4'd10, 32'd1, 32'd2, 1'b0));
        send_word(make_word(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_word(make_word(iamd_pkg::OP_DIVU, 32'd100, 32'h0000_FFFF, 1'b1));
    endtask

    task automatic test_random(int count);
        iamd_pkg::in_word_t w;
        repeat (count)
        begin
            w = '0;
            w.kind = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                 : 4'($urandom_range(0, 9));
            w.operand_a = pick_operand();
            w.operand_b = pick_operand();
            w.immediate = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom);
            w.use_immediate = 1'($urandom_range(0, 1));
            w.current_pc = $urandom;
            send_word(w);
        end
    endtask

    // the receiver stops long enough for the queue and pipe to fill
    task automatic test_backpressure();
        hold_off = 150;
        test_random(80);
    endtask

    initial
    begin
        int drain;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(500);
        test_backpressure();
        quiet = 1'b1;
        test_random(320);
        in_valid <= 1'b0;
        drain = 0;
        while (expected_words.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (LATENCY + 5) @(posedge clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- sim.f -----
design/iamd_pkg.sv
design/iamd_front.sv
design/iamd_queue.sv
design/iamd_back.sv
design/integer_alu_mul_div_top.sv
tb/tb.sv
